>>> sv/hrfw_pkg.sv
package hrfw_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned PosW     = 10;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned HalfW    = 16;
  localparam int unsigned IndexW   = 7;
  localparam int unsigned TdataOutW = AddrW + HalfW;

  localparam logic [PosW-1:0]  PosMax       = 10'd1023;
  localparam logic [PosW-1:0]  PosCount     = 10'd2;
  localparam logic [PosW-1:0]  PosOffset    = 10'd6;
  localparam logic [PosW-1:0]  PosType      = 10'd8;
  localparam logic [PosW-1:0]  PosFirstData = 10'd9;
  localparam logic [PosW-1:0]  PosUpper     = 10'd12;
  localparam logic [15:0]      UpperReset   = 16'h0800;

  localparam logic [CharW-1:0] CharZero = 8'h30;
  localparam logic [CharW-1:0] CharNine = 8'h39;
  localparam logic [CharW-1:0] CharA    = 8'h41;
  localparam logic [CharW-1:0] CharF    = 8'h46;
  localparam logic [CharW-1:0] CharFour = 8'h34;
  localparam logic [CharW-1:0] AlphaBias = 8'h37;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_UPPER = 2'd2
  } kind_e;

  typedef struct packed {
    logic [AddrW-1:0] write_address;
    logic [HalfW-1:0] halfword_data;
    logic             last_of_record;
  } result_t;

  function automatic logic [3:0] hex_digit(input logic [CharW-1:0] c);
    logic [CharW-1:0] d;
    d = 8'd0;
    if (c >= CharZero && c <= CharNine) begin
      d = c - CharZero;
    end else if (c >= CharA && c <= CharF) begin
      d = c - AlphaBias;
    end
    return d[3:0];
  endfunction

endpackage

>>> sv/hrfw_parser.sv
module hrfw_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic [hrfw_pkg::CharW-1:0]  ascii_char_i,
  input  logic                        record_start_i,
  output logic                        res_valid_o,
  output hrfw_pkg::result_t           res_o
);
  import hrfw_pkg::*;

  logic [PosW-1:0]   char_pos_q, char_pos_d;
  logic [7:0]        byte_count_q, byte_count_d;
  logic [15:0]       offset_q, offset_d;
  kind_e             kind_q, kind_d;
  logic [15:0]       upper_q, upper_d;
  logic [11:0]       collector_q, collector_d;
  logic [IndexW-1:0] index_q, index_d;

  logic [PosW-1:0]   pos;
  logic [3:0]        nib;
  logic [15:0]       value;
  logic              group_start;
  logic              emit_slot;
  logic [IndexW-1:0] halves;
  logic [AddrW-1:0]  base_addr;

  always_comb begin
    pos         = record_start_i ? '0 : char_pos_q;
    nib         = hex_digit(ascii_char_i);
    group_start = (pos == 10'd1) || (pos == 10'd3) ||
                  (pos >= PosFirstData && pos[1:0] == 2'b01);
    value       = group_start ? {12'd0, nib} : {collector_q, nib};
    emit_slot   = (pos >= PosUpper) && (pos[1:0] == 2'b00);
    halves      = byte_count_q[7:1];
    base_addr   = {upper_q, offset_q};

    collector_d  = value[11:0];
    byte_count_d = byte_count_q;
    offset_d     = offset_q;
    kind_d       = kind_q;
    upper_d      = upper_q;
    index_d      = index_q;
    char_pos_d   = (pos < PosMax) ? pos + 10'd1 : PosMax;
    res_valid_o  = 1'b0;

    res_o.write_address  = base_addr + {{(AddrW-IndexW-1){1'b0}}, index_q, 1'b0};
    res_o.halfword_data  = {value[7:0], value[15:8]};
    res_o.last_of_record = ({1'b0, index_q} + 8'd1) == {1'b0, halves};

    if (pos == '0) begin
      kind_d  = KIND_OTHER;
      index_d = '0;
    end else if (pos == PosCount) begin
      byte_count_d = value[7:0];
    end else if (pos == PosOffset) begin
      offset_d = value;
    end else if (pos == PosType) begin
      if (ascii_char_i == CharZero) begin
        kind_d = KIND_DATA;
      end else if (ascii_char_i == CharFour) begin
        kind_d = KIND_UPPER;
      end else begin
        kind_d = KIND_OTHER;
      end
    end else if (emit_slot) begin
      if (kind_q == KIND_UPPER && pos == PosUpper) begin
        upper_d = value;
      end else if (kind_q == KIND_DATA && index_q < halves) begin
        res_valid_o = 1'b1;
        index_d     = index_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_pos_q   <= '0;
      byte_count_q <= '0;
      offset_q     <= '0;
      kind_q       <= KIND_OTHER;
      upper_q      <= UpperReset;
      collector_q  <= '0;
      index_q      <= '0;
    end else if (fire_i) begin
      char_pos_q   <= char_pos_d;
      byte_count_q <= byte_count_d;
      offset_q     <= offset_d;
      kind_q       <= kind_d;
      upper_q      <= upper_d;
      collector_q  <= collector_d;
      index_q      <= index_d;
    end
  end

endmodule

>>> sv/hex_record_flash_writer.sv
// Hex record flash writer. The block takes the text of hex records one
// character per request on the slave side, with tuser marking the first
// character of each record, and emits one request per halfword to program on
// the master side. Only uppercase hex digits are decoded; any other character
// counts as digit zero. Data records produce byte_count/2 halfwords at
// consecutive flash addresses, the last one flagged by tlast; an odd trailing
// byte is dropped. Extended linear address records set the upper 16 address
// bits, which start at 0x0800 after reset and persist across records. Other
// record types and the checksum are ignored. The block takes one character
// every clock cycle: the field decode and address add sit between the
// position and field registers and a two-entry output buffer, so a character
// is accepted whenever the buffer has a free entry, which is every cycle while
// the downstream side keeps up.
module hex_record_flash_writer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [7:0] ascii_char
  input  logic [hrfw_pkg::CharW-1:0]      s_axis_tdata_i,
  // [0] record_start
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [31:0] write_address, [47:32] halfword_data
  output logic [hrfw_pkg::TdataOutW-1:0]  m_axis_tdata_o,
  // last_of_record
  output logic                            m_axis_tlast_o
);
  import hrfw_pkg::*;

  logic    in_fire;
  logic    res_valid;
  result_t res;

  // Output register plus a skid entry. The slave side is ready whenever the
  // skid entry is free, so a waiting result never stalls the parser by itself.
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;
  logic    skid_valid_q, skid_valid_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign s_axis_tready_o = !skid_valid_q;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  hrfw_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (in_fire),
    .ascii_char_i   (s_axis_tdata_i),
    .record_start_i (s_axis_tuser_i),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  always_comb begin
    pop          = out_valid_q && m_axis_tready_i;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      // The output slot is free this cycle; the older skid entry moves first.
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = in_fire && res_valid;
        skid_d       = res;
      end else begin
        out_valid_d = in_fire && res_valid;
        out_d       = res;
      end
    end else if (in_fire && res_valid) begin
      // Output still held downstream: park the new result in the skid entry.
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.halfword_data, out_q.write_address};
  assign m_axis_tlast_o  = out_q.last_of_record;

endmodule
